// ----- rtl/cda_pkg.sv -----
// ============================================================================
// cda_pkg
// Shared types, opcodes and calendar helpers for the date arithmetic block.
// ============================================================================
package cda_pkg;

    localparam int OPCODE_W = 4;
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;

    localparam int DEFAULT_MAX_AMOUNT_BITS = 12;

    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [YEAR_W-1:0]  YEAR_RESET = 14'd2000;
    localparam logic [MONTH_W-1:0] DECEMBER   = 4'd12;
    localparam logic [MONTH_W-1:0] JANUARY    = 4'd1;
    localparam logic [DAY_W-1:0]   LAST_DAY   = 5'd31;

    // first month count past the last representable year
    localparam int MONTHS_LIMIT = (9999 + 1) * 12;

    // fixed-point reciprocal of 100, exact for any 14-bit year
    localparam int RECIP_100_SHIFT = 19;
    localparam logic [12:0] RECIP_100 = 13'd5243;

    // month counts split into year and month stay below MONTHS_LIMIT
    localparam int MONTH_SPLIT_W = 17;

    // fixed-point reciprocal of 12, exact for any 17-bit month count
    localparam int DIV12_SHIFT = 20;
    localparam logic [MONTH_SPLIT_W-1:0] RECIP_12 = 17'd87382;

    localparam logic [OPCODE_W-1:0] OP_LOAD      = 4'd0;
    localparam logic [OPCODE_W-1:0] OP_SET_MONTH = 4'd1;
    localparam logic [OPCODE_W-1:0] OP_SET_YEAR  = 4'd2;
    localparam logic [OPCODE_W-1:0] OP_ADD_DAYS  = 4'd3;
    localparam logic [OPCODE_W-1:0] OP_ADD_MON   = 4'd4;
    localparam logic [OPCODE_W-1:0] OP_SUB_MON   = 4'd5;
    localparam logic [OPCODE_W-1:0] OP_ADD_YEARS = 4'd6;
    localparam logic [OPCODE_W-1:0] OP_SUB_YEARS = 4'd7;
    localparam logic [OPCODE_W-1:0] OP_COMPARE   = 4'd8;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MPREP = 8'b0000_0010,
        ST_DIV   = 8'b0000_0100,
        ST_MFIN  = 8'b0000_1000,
        ST_LEAP1 = 8'b0001_0000,
        ST_LEAP2 = 8'b0010_0000,
        ST_CLAMP = 8'b0100_0000,
        ST_DAYS  = 8'b1000_0000
    } state_t;

    function automatic logic [DAY_W-1:0] days_in_month(
        input logic [MONTH_W-1:0] m,
        input logic               leap
    );
        logic [DAY_W-1:0] len;
        begin
            unique case (m)
                4'd2:                      len = leap ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
                default:                   len = 5'd31;
            endcase
            return len;
        end
    endfunction

    function automatic logic [MONTH_W-1:0] fix_month(input logic [MONTH_W-1:0] m);
        logic [MONTH_W-1:0] r;
        begin
            if (m == 4'd0) begin
                r = JANUARY;
            end else if (m > DECEMBER) begin
                r = DECEMBER;
            end else begin
                r = m;
            end
            return r;
        end
    endfunction

endpackage

// ----- rtl/calendar_date_arithmetic.sv -----
// ============================================================================
// calendar_date_arithmetic
// Holds one Gregorian date and applies one operation per item.
// ============================================================================
// An item is taken when start is high and busy is low; opcode, amount and the
// arg_* fields are sampled at that edge. The result is on cur_day, cur_month,
// cur_year, the compare flags and year_saturated for the one cycle that done
// is high; done rises in the cycle busy falls, and a new item may be started
// in that same cycle. The receiver cannot stall the block.
// Steps: compare and unused opcodes finish from idle; set month goes to the
// day clamp; load, set year and add/sub years run the leap-year check of the
// new year (ST_LEAP1, ST_LEAP2), then a day clamp; add/sub months run a
// reciprocal multiply by 1/12, remainder, leap check and clamp, and skip the
// multiply and remainder when the year saturates. Add days walks one month
// per cycle through a single day adder/compare, held for the leap check of
// each year crossed.
// Reset leaves 1 January 2000 with no item in flight.
// ============================================================================
module calendar_date_arithmetic #(
    parameter int MAX_AMOUNT_BITS = cda_pkg::DEFAULT_MAX_AMOUNT_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    output logic                          done,
    input  logic [cda_pkg::OPCODE_W-1:0]  opcode,
    input  logic [MAX_AMOUNT_BITS-1:0]    amount,
    input  logic [cda_pkg::DAY_W-1:0]     arg_day,
    input  logic [cda_pkg::MONTH_W-1:0]   arg_month,
    input  logic [cda_pkg::YEAR_W-1:0]    arg_year,
    output logic [cda_pkg::DAY_W-1:0]     cur_day,
    output logic [cda_pkg::MONTH_W-1:0]   cur_month,
    output logic [cda_pkg::YEAR_W-1:0]    cur_year,
    output logic                          is_less,
    output logic                          is_equal,
    output logic                          is_greater,
    output logic                          year_saturated
);

    localparam int LW = MAX_AMOUNT_BITS;
    localparam int AW = ((MAX_AMOUNT_BITS > cda_pkg::DAY_W) ? MAX_AMOUNT_BITS
                                                             : cda_pkg::DAY_W) + 1;
    localparam int TW = $clog2(9999 * 12 + 12 + 2 ** MAX_AMOUNT_BITS);
    localparam int QW = cda_pkg::MONTH_SPLIT_W;
    localparam int DW = cda_pkg::DAY_W;
    localparam int MW = cda_pkg::MONTH_W;
    localparam int YW = cda_pkg::YEAR_W;

    cda_pkg::state_t state_reg, state_next;

    logic [DW-1:0]                 day_reg, day_next;
    logic [MW-1:0]                 month_reg, month_next;
    logic [YW-1:0]                 year_reg, year_next;
    logic                          leap_reg, leap_next;
    logic [cda_pkg::OPCODE_W-1:0]  op_reg, op_next;
    logic [LW-1:0]                 left_reg, left_next;
    logic [TW-1:0]                 t_reg, t_next;
    logic [YW-1:0]                 quo_reg, quo_next;
    logic [7:0]                    q_reg, q_next;
    logic                          lt_reg, lt_next;
    logic                          eq_reg, eq_next;
    logic                          gt_reg, gt_next;
    logic                          sat_reg, sat_next;
    logic                          done_reg, done_next;

    logic [DW-1:0]    lim;
    logic [AW-1:0]    day_sum;
    logic [TW-1:0]    month_base;
    logic [TW-1:0]    month_sum;
    logic [TW-1:0]    year_sum;
    logic [QW-1:0]    div_in;
    logic [2*QW-1:0]  div_prod;
    logic [QW-1:0]    quo_times_12;
    logic [QW-1:0]    div_rem;
    logic [26:0]      recip_prod;
    logic [14:0]      q_times_100;
    logic [22:0]      held_key;
    logic [22:0]      arg_key;

    // one shared day/month length unit for clamp and day walking
    assign lim     = cda_pkg::days_in_month(month_reg, leap_reg);
    assign day_sum = AW'(day_reg) + AW'(left_reg);

    assign month_base = (TW'(year_reg) << 3) + (TW'(year_reg) << 2)
                        + TW'(month_reg) - TW'(1);
    assign month_sum  = month_base + TW'(left_reg);
    assign year_sum   = TW'(year_reg) + TW'(amount);

    // month count split into year and month: t_reg stays below MONTHS_LIMIT here
    assign div_in       = QW'(t_reg);
    assign div_prod     = div_in * cda_pkg::RECIP_12;
    assign quo_times_12 = (QW'(quo_reg) << 3) + (QW'(quo_reg) << 2);
    assign div_rem      = div_in - quo_times_12;

    assign recip_prod  = year_reg * cda_pkg::RECIP_100;
    assign q_times_100 = {1'b0, q_reg, 6'b0} + {2'b0, q_reg, 5'b0} + {5'b0, q_reg, 2'b0};

    assign held_key = {year_reg, month_reg, day_reg};
    assign arg_key  = {arg_year, arg_month, arg_day};

    always_comb
    begin
        state_next = state_reg;
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        leap_next  = leap_reg;
        op_next    = op_reg;
        left_next  = left_reg;
        t_next     = t_reg;
        quo_next   = quo_reg;
        q_next     = q_reg;
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        gt_next    = gt_reg;
        sat_next   = sat_reg;
        done_next  = 1'b0;

        unique case (state_reg)
            cda_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    op_next   = opcode;
                    left_next = amount;
                    lt_next   = 1'b0;
                    eq_next   = 1'b0;
                    gt_next   = 1'b0;
                    sat_next  = 1'b0;
                    unique case (opcode)
                        cda_pkg::OP_LOAD:
                        begin
                            if (arg_year > cda_pkg::YEAR_MAX)
                            begin
                                year_next = cda_pkg::YEAR_MAX;
                                sat_next  = 1'b1;
                            end
                            else
                            begin
                                year_next = arg_year;
                            end
                            month_next = cda_pkg::fix_month(arg_month);
                            day_next   = arg_day;
                            state_next = cda_pkg::ST_LEAP1;
                        end
                        cda_pkg::OP_SET_MONTH:
                        begin
                            month_next = cda_pkg::fix_month(arg_month);
                            state_next = cda_pkg::ST_CLAMP;
                        end
                        cda_pkg::OP_SET_YEAR:
                        begin
                            if (arg_year > cda_pkg::YEAR_MAX)
                            begin
                                year_next = cda_pkg::YEAR_MAX;
                                sat_next  = 1'b1;
                            end
                            else
                            begin
                                year_next = arg_year;
                            end
                            state_next = cda_pkg::ST_LEAP1;
                        end
                        cda_pkg::OP_ADD_DAYS:
                        begin
                            state_next = cda_pkg::ST_DAYS;
                        end
                        cda_pkg::OP_ADD_MON, cda_pkg::OP_SUB_MON:
                        begin
                            state_next = cda_pkg::ST_MPREP;
                        end
                        cda_pkg::OP_ADD_YEARS:
                        begin
                            if (year_sum > TW'(cda_pkg::YEAR_MAX))
                            begin
                                year_next = cda_pkg::YEAR_MAX;
                                sat_next  = 1'b1;
                            end
                            else
                            begin
                                year_next = YW'(year_sum);
                            end
                            state_next = cda_pkg::ST_LEAP1;
                        end
                        cda_pkg::OP_SUB_YEARS:
                        begin
                            if (TW'(amount) > TW'(year_reg))
                            begin
                                year_next = '0;
                                sat_next  = 1'b1;
                            end
                            else
                            begin
                                year_next = YW'(TW'(year_reg) - TW'(amount));
                            end
                            state_next = cda_pkg::ST_LEAP1;
                        end
                        cda_pkg::OP_COMPARE:
                        begin
                            lt_next   = held_key < arg_key;
                            eq_next   = held_key == arg_key;
                            gt_next   = held_key > arg_key;
                            done_next = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            cda_pkg::ST_MPREP:
            begin
                t_next = month_base;
                if (op_reg == cda_pkg::OP_ADD_MON)
                begin
                    if (month_sum >= TW'(cda_pkg::MONTHS_LIMIT))
                    begin
                        year_next  = cda_pkg::YEAR_MAX;
                        month_next = cda_pkg::DECEMBER;
                        sat_next   = 1'b1;
                        state_next = cda_pkg::ST_LEAP1;
                    end
                    else
                    begin
                        t_next     = month_sum;
                        state_next = cda_pkg::ST_DIV;
                    end
                end
                else
                begin
                    if (TW'(left_reg) > month_base)
                    begin
                        year_next  = '0;
                        month_next = cda_pkg::JANUARY;
                        sat_next   = 1'b1;
                        state_next = cda_pkg::ST_LEAP1;
                    end
                    else
                    begin
                        t_next     = month_base - TW'(left_reg);
                        state_next = cda_pkg::ST_DIV;
                    end
                end
            end

            // year = month count / 12 by reciprocal multiply
            cda_pkg::ST_DIV:
            begin
                quo_next   = div_prod[cda_pkg::DIV12_SHIFT +: YW];
                state_next = cda_pkg::ST_MFIN;
            end

            cda_pkg::ST_MFIN:
            begin
                year_next  = quo_reg;
                month_next = MW'(div_rem) + MW'(1);
                state_next = cda_pkg::ST_LEAP1;
            end

            cda_pkg::ST_LEAP1:
            begin
                q_next     = recip_prod[26:19];
                state_next = cda_pkg::ST_LEAP2;
            end

            // divisible by 4, and not a century unless divisible by 400
            cda_pkg::ST_LEAP2:
            begin
                leap_next = (year_reg[1:0] == 2'b00)
                            && (({1'b0, year_reg} != q_times_100) || (q_reg[1:0] == 2'b00));
                if (op_reg == cda_pkg::OP_ADD_DAYS)
                begin
                    state_next = cda_pkg::ST_DAYS;
                end
                else
                begin
                    state_next = cda_pkg::ST_CLAMP;
                end
            end

            cda_pkg::ST_CLAMP:
            begin
                if (day_reg > lim)
                begin
                    day_next = lim;
                end
                else if (day_reg == '0)
                begin
                    day_next = DW'(1);
                end
                done_next  = 1'b1;
                state_next = cda_pkg::ST_IDLE;
            end

            // one month per cycle, held for the leap check when a year is crossed
            cda_pkg::ST_DAYS:
            begin
                if (left_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = cda_pkg::ST_IDLE;
                end
                else if (day_sum <= AW'(lim))
                begin
                    day_next   = DW'(day_sum);
                    left_next  = '0;
                    done_next  = 1'b1;
                    state_next = cda_pkg::ST_IDLE;
                end
                else
                begin
                    left_next = left_reg - LW'(lim - day_reg) - LW'(1);
                    day_next  = DW'(1);
                    if (month_reg >= cda_pkg::DECEMBER)
                    begin
                        if (year_reg >= cda_pkg::YEAR_MAX)
                        begin
                            month_next = cda_pkg::DECEMBER;
                            day_next   = cda_pkg::LAST_DAY;
                            sat_next   = 1'b1;
                            left_next  = '0;
                            done_next  = 1'b1;
                            state_next = cda_pkg::ST_IDLE;
                        end
                        else
                        begin
                            month_next = cda_pkg::JANUARY;
                            year_next  = year_reg + YW'(1);
                            state_next = cda_pkg::ST_LEAP1;
                        end
                    end
                    else
                    begin
                        month_next = month_reg + MW'(1);
                    end
                end
            end

            default:
            begin
                state_next = cda_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cda_pkg::ST_IDLE;
            day_reg   <= DW'(1);
            month_reg <= cda_pkg::JANUARY;
            year_reg  <= cda_pkg::YEAR_RESET;
            leap_reg  <= 1'b1;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
            gt_reg    <= 1'b0;
            sat_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            leap_reg  <= leap_next;
            lt_reg    <= lt_next;
            eq_reg    <= eq_next;
            gt_reg    <= gt_next;
            sat_reg   <= sat_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        left_reg <= left_next;
        t_reg    <= t_next;
        quo_reg  <= quo_next;
        q_reg    <= q_next;
    end

    assign busy           = (state_reg != cda_pkg::ST_IDLE);
    assign done           = done_reg;
    assign cur_day        = day_reg;
    assign cur_month      = month_reg;
    assign cur_year       = year_reg;
    assign is_less        = lt_reg;
    assign is_equal       = eq_reg;
    assign is_greater     = gt_reg;
    assign year_saturated = sat_reg;

`ifndef SYNTHESIS
    // a result never shows while the sequencer is still working
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done raised while busy");

    a_compare_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == cda_pkg::OP_COMPARE) |=> (done && !busy))
        else $error("compare item did not finish in one cycle");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({is_less, is_equal, is_greater}))
        else $error("more than one compare flag set");

    // held date stays a real calendar date between items
    a_date_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (cur_day != '0 && cur_day <= lim && cur_month != '0
                   && cur_month <= cda_pkg::DECEMBER && cur_year <= cda_pkg::YEAR_MAX))
        else $error("held date out of range while idle");
`endif

endmodule

// ----- dv/date_check_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// date_check_pkg
// Date predictor and result scoreboard for the calendar date arithmetic block.
// Tracks the held date item by item and checks every result strobe, in order.
// ============================================================================
package date_check_pkg;

    import cda_pkg::*;

    localparam int AMT_W = DEFAULT_MAX_AMOUNT_BITS;
    localparam int KEY_W = YEAR_W + MONTH_W + DAY_W;

    // opcodes the block treats as no-ops
    localparam logic [OPCODE_W-1:0] OP_FIRST_UNUSED = 4'd9;
    localparam logic [OPCODE_W-1:0] OP_LAST_UNUSED  = 4'd15;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic               lt;
        logic               eq;
        logic               gt;
        logic               sat;
    } date_result_t;

    class date_scoreboard;

        int unsigned  held_day;
        int unsigned  held_month;
        int unsigned  held_year;
        date_result_t pending_dates[$];
        int unsigned  op_count[16];
        int unsigned  results_seen;
        int unsigned  mismatches;
        int unsigned  saturations;
        int unsigned  less_seen;
        int unsigned  equal_seen;
        int unsigned  greater_seen;

        function new();
            held_day   = 1;
            held_month = JANUARY;
            held_year  = YEAR_RESET;
        endfunction

        function bit leap_year(int unsigned y);
            return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        endfunction

        function int unsigned month_length(int unsigned m, int unsigned y);
            case (m)
                2:           return leap_year(y) ? 29 : 28;
                4, 6, 9, 11: return 30;
                default:     return 31;
            endcase
        endfunction

        function void clamp_day();
            int unsigned lim;
            lim = month_length(held_month, held_year);
            if (held_day > lim)
                held_day = lim;
            if (held_day < 1)
                held_day = 1;
        endfunction

        function int unsigned legal_month(int unsigned m);
            if (m < JANUARY)
                return JANUARY;
            if (m > DECEMBER)
                return DECEMBER;
            return m;
        endfunction

        // advance the held date by one item and queue the expected result
        function void note_item(logic [OPCODE_W-1:0] op, logic [AMT_W-1:0] amt,
                                logic [DAY_W-1:0] ad, logic [MONTH_W-1:0] am,
                                logic [YEAR_W-1:0] ay);
            int unsigned  left;
            int unsigned  lim;
            int unsigned  total;
            int unsigned  year_arg;
            logic [KEY_W-1:0] held_key;
            logic [KEY_W-1:0] arg_key;
            date_result_t r;
            r = '0;
            year_arg = ay;
            case (op)
                OP_LOAD:
                begin
                    if (year_arg > YEAR_MAX)
                    begin
                        year_arg = YEAR_MAX;
                        r.sat = 1'b1;
                    end
                    held_year  = year_arg;
                    held_month = legal_month(am);
                    held_day   = ad;
                    clamp_day();
                end
                OP_SET_MONTH:
                begin
                    held_month = legal_month(am);
                    clamp_day();
                end
                OP_SET_YEAR:
                begin
                    if (year_arg > YEAR_MAX)
                    begin
                        year_arg = YEAR_MAX;
                        r.sat = 1'b1;
                    end
                    held_year = year_arg;
                    clamp_day();
                end
                OP_ADD_DAYS:
                begin
                    left = amt;
                    while (left > 0)
                    begin
                        lim = month_length(held_month, held_year);
                        if (held_day + left <= lim)
                        begin
                            held_day += left;
                            left = 0;
                        end
                        else
                        begin
                            left -= lim - held_day + 1;
                            held_day = 1;
                            if (held_month >= DECEMBER)
                            begin
                                // stop at the last day of the last year
                                if (held_year >= YEAR_MAX)
                                begin
                                    held_month = DECEMBER;
                                    held_day   = LAST_DAY;
                                    r.sat      = 1'b1;
                                    left       = 0;
                                end
                                else
                                begin
                                    held_month = JANUARY;
                                    held_year++;
                                end
                            end
                            else
                                held_month++;
                        end
                    end
                end
                OP_ADD_MON:
                begin
                    total = held_year * 12 + (held_month - 1) + amt;
                    if (total / 12 > YEAR_MAX)
                    begin
                        held_year  = YEAR_MAX;
                        held_month = DECEMBER;
                        r.sat      = 1'b1;
                    end
                    else
                    begin
                        held_year  = total / 12;
                        held_month = total % 12 + 1;
                    end
                    clamp_day();
                end
                OP_SUB_MON:
                begin
                    total = held_year * 12 + (held_month - 1);
                    if (amt > total)
                    begin
                        held_year  = 0;
                        held_month = JANUARY;
                        r.sat      = 1'b1;
                    end
                    else
                    begin
                        total -= amt;
                        held_year  = total / 12;
                        held_month = total % 12 + 1;
                    end
                    clamp_day();
                end
                OP_ADD_YEARS:
                begin
                    if (held_year + amt > YEAR_MAX)
                    begin
                        held_year = YEAR_MAX;
                        r.sat     = 1'b1;
                    end
                    else
                        held_year += amt;
                    clamp_day();
                end
                OP_SUB_YEARS:
                begin
                    if (amt > held_year)
                    begin
                        held_year = 0;
                        r.sat     = 1'b1;
                    end
                    else
                        held_year -= amt;
                    clamp_day();
                end
                OP_COMPARE:
                begin
                    // arguments compared raw, no clamping
                    held_key = {held_year[YEAR_W-1:0], held_month[MONTH_W-1:0],
                                held_day[DAY_W-1:0]};
                    arg_key  = {ay, am, ad};
                    r.lt = held_key < arg_key;
                    r.eq = held_key == arg_key;
                    r.gt = held_key > arg_key;
                end
                default:
                begin
                end
            endcase
            r.day   = held_day[DAY_W-1:0];
            r.month = held_month[MONTH_W-1:0];
            r.year  = held_year[YEAR_W-1:0];
            pending_dates.push_back(r);
            op_count[op]++;
        endfunction

        function string describe(date_result_t r);
            return $sformatf("%0d/%0d/%0d lt=%0b eq=%0b gt=%0b sat=%0b",
                             r.day, r.month, r.year, r.lt, r.eq, r.gt, r.sat);
        endfunction

        function void flag_mismatch(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch: %s", $realtime, what);
        endfunction

        function void check_result(date_result_t got);
            date_result_t want;
            results_seen++;
            if (pending_dates.size() == 0)
            begin
                flag_mismatch({"result with no item pending: ", describe(got)});
                return;
            end
            want = pending_dates.pop_front();
            if (got !== want)
                flag_mismatch({"expected ", describe(want), ", got ", describe(got)});
            saturations  += want.sat;
            less_seen    += want.lt;
            equal_seen   += want.eq;
            greater_seen += want.gt;
        endfunction

        function int unsigned pending();
            return pending_dates.size();
        endfunction

        function void summary();
            int unsigned unused_ops;
            int unsigned items;
            unused_ops = 0;
            items = 0;
            for (int i = 0; i < 16; i++)
            begin
                items += op_count[i];
                if (i >= OP_FIRST_UNUSED)
                    unused_ops += op_count[i];
            end
            $display("covered %0d items: %0d loads, %0d day adds, %0d month ops, %0d year ops, %0d compares, %0d unused opcodes",
                     items, op_count[OP_LOAD], op_count[OP_ADD_DAYS],
                     op_count[OP_SET_MONTH] + op_count[OP_ADD_MON] + op_count[OP_SUB_MON],
                     op_count[OP_SET_YEAR] + op_count[OP_ADD_YEARS] + op_count[OP_SUB_YEARS],
                     op_count[OP_COMPARE], unused_ops);
            $display("checked %0d results: %0d saturated, compare lt/eq/gt %0d/%0d/%0d, %0d mismatches",
                     results_seen, saturations, less_seen, equal_seen, greater_seen,
                     mismatches);
        endfunction

    endclass

endpackage

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Testbench for calendar_date_arithmetic: directed corner items, then random
// date sequences with random sender gaps; every result strobe is checked.
// ============================================================================
module tb_top;

    import cda_pkg::*;
    import date_check_pkg::*;

    localparam int TOTAL_ITEMS = 1450;
    localparam int QUIET_LIMIT = 3000;
    localparam int TAIL_CYCLES = 200;
    localparam int DRAIN_EVERY = 300;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [OPCODE_W-1:0]  opcode = OP_LOAD;
    logic [AMT_W-1:0]     amount = '0;
    logic [DAY_W-1:0]     arg_day = '0;
    logic [MONTH_W-1:0]   arg_month = '0;
    logic [YEAR_W-1:0]    arg_year = '0;
    logic                 busy;
    logic                 done;
    logic [DAY_W-1:0]     cur_day;
    logic [MONTH_W-1:0]   cur_month;
    logic [YEAR_W-1:0]    cur_year;
    logic                 is_less;
    logic                 is_equal;
    logic                 is_greater;
    logic                 year_saturated;

    date_scoreboard sb = new();
    int unsigned    quiet_cycles = 0;
    int unsigned    items_sent = 0;
    bit             no_idle = 1'b0;

    calendar_date_arithmetic dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .done           (done),
        .opcode         (opcode),
        .amount         (amount),
        .arg_day        (arg_day),
        .arg_month      (arg_month),
        .arg_year       (arg_year),
        .cur_day        (cur_day),
        .cur_month      (cur_month),
        .cur_year       (cur_year),
        .is_less        (is_less),
        .is_equal       (is_equal),
        .is_greater     (is_greater),
        .year_saturated (year_saturated)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // result check, item tracking and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(date_result_t'({cur_day, cur_month, cur_year, is_less,
                                                is_equal, is_greater, year_saturated}));
            if (start && !busy)
                sb.note_item(opcode, amount, arg_day, arg_month, arg_year);
            if (done || (start && !busy))
                quiet_cycles <= 0;
            else if (quiet_cycles >= QUIET_LIMIT - 1)
            begin
                $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [AMT_W-1:0] rand_amount();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return AMT_W'($urandom_range(0, 40));
            5, 6, 7:       return AMT_W'($urandom_range(0, 400));
            8:             return AMT_W'($urandom_range(0, 4095));
            default:       return $urandom_range(0, 1) ? 12'd4095 : 12'd0;
        endcase
    endfunction

    function automatic logic [YEAR_W-1:0] rand_year();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return YEAR_W'($urandom_range(0, 9999));
            4, 5:       return YEAR_W'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                            : $urandom_range(9996, 9999));
            6, 7:       return YEAR_W'($urandom_range(1600, 2400));
            8:          return YEAR_W'($urandom_range(10000, 16383));
            default:    return YEAR_W'($urandom_range(0, 16383));
        endcase
    endfunction

    function automatic logic [DAY_W-1:0] rand_day();
        return DAY_W'(($urandom_range(0, 6) == 0) ? $urandom_range(0, 31)
                                                  : $urandom_range(1, 31));
    endfunction

    function automatic logic [MONTH_W-1:0] rand_month();
        return MONTH_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                    : $urandom_range(1, 12));
    endfunction

    function automatic logic [YEAR_W-1:0] leapish_year();
        case ($urandom_range(0, 2))
            0:       return YEAR_W'(4 * $urandom_range(0, 2499));
            1:       return YEAR_W'(100 * $urandom_range(0, 99));
            default: return YEAR_W'(400 * $urandom_range(0, 24));
        endcase
    endfunction

    // hold the item until the block takes it, then maybe leave a gap
    task automatic issue_item(input logic [OPCODE_W-1:0] op, input logic [AMT_W-1:0] amt,
                              input logic [DAY_W-1:0] d, input logic [MONTH_W-1:0] m,
                              input logic [YEAR_W-1:0] y);
        int unsigned gap;
        opcode    <= op;
        amount    <= amt;
        arg_day   <= d;
        arg_month <= m;
        arg_year  <= y;
        start     <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
        gap = pick_gap();
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic random_op();
        logic [OPCODE_W-1:0] op;
        if ($urandom_range(0, 19) == 0)
            op = OPCODE_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
        else
            op = OPCODE_W'($urandom_range(OP_LOAD, OP_COMPARE));
        issue_item(op, rand_amount(), rand_day(), rand_month(), rand_year());
    endtask

    task automatic arith_op();
        issue_item(OPCODE_W'($urandom_range(OP_SET_MONTH, OP_SUB_YEARS)), rand_amount(),
                   rand_day(), rand_month(), rand_year());
    endtask

    // load a plain date, then compare against it, a near neighbor or a random date
    task automatic load_and_compare();
        logic [DAY_W-1:0]   d;
        logic [MONTH_W-1:0] m;
        logic [YEAR_W-1:0]  y;
        d = DAY_W'($urandom_range(1, 28));
        m = MONTH_W'($urandom_range(1, 12));
        y = YEAR_W'($urandom_range(0, 9999));
        issue_item(OP_LOAD, rand_amount(), d, m, y);
        case ($urandom_range(0, 4))
            0, 1: issue_item(OP_COMPARE, rand_amount(), d, m, y);
            2:    issue_item(OP_COMPARE, rand_amount(), d ^ 5'd1, m, y);
            3:    issue_item(OP_COMPARE, rand_amount(), d, m ^ 4'd1, y);
            default: issue_item(OP_COMPARE, rand_amount(), rand_day(), rand_month(),
                                rand_year());
        endcase
    endtask

    // month ends, leap days and the year limits
    task automatic edge_walk();
        int unsigned steps;
        steps = $urandom_range(1, 3);
        case ($urandom_range(0, 3))
            0:
            begin
                issue_item(OP_LOAD, '0, LAST_DAY, MONTH_W'($urandom_range(1, 12)),
                           rand_year());
                repeat (steps)
                    issue_item($urandom_range(0, 1) ? OP_ADD_DAYS : OP_ADD_MON,
                               AMT_W'($urandom_range(0, 3)), rand_day(), rand_month(),
                               rand_year());
            end
            1:
            begin
                issue_item(OP_LOAD, '0, 5'd29, 4'd2, leapish_year());
                repeat (steps)
                    issue_item(OPCODE_W'($urandom_range(OP_SET_YEAR, OP_SUB_YEARS)),
                               $urandom_range(0, 1) ? AMT_W'($urandom_range(1, 4))
                                                    : AMT_W'(12),
                               rand_day(), rand_month(), leapish_year());
            end
            2:
            begin
                issue_item(OP_LOAD, '0, rand_day(), DECEMBER,
                           YEAR_W'($urandom_range(9997, 9999)));
                repeat (steps)
                    issue_item($urandom_range(0, 1) ? OP_ADD_DAYS : OP_ADD_MON,
                               rand_amount(), rand_day(), rand_month(), rand_year());
            end
            default:
            begin
                issue_item(OP_LOAD, '0, rand_day(), MONTH_W'($urandom_range(1, 2)),
                           YEAR_W'($urandom_range(0, 2)));
                repeat (steps)
                    issue_item($urandom_range(0, 1) ? OP_SUB_MON : OP_SUB_YEARS,
                               rand_amount(), rand_day(), rand_month(), rand_year());
            end
        endcase
    endtask

    initial
    begin
        int unsigned scenario;
        int unsigned next_drain;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        issue_item(OP_COMPARE, '0, 5'd1, JANUARY, YEAR_RESET);
        issue_item(OP_ADD_DAYS, '0, '0, '0, '0);
        issue_item(OP_LOAD, '0, LAST_DAY, DECEMBER, YEAR_MAX);
        issue_item(OP_ADD_DAYS, 12'd1, '0, '0, '0);
        issue_item(OP_LOAD, '0, 5'd31, DECEMBER, 14'd2023);
        issue_item(OP_ADD_DAYS, 12'd1, '0, '0, '0);
        issue_item(OP_LOAD, '0, 5'd29, 4'd2, 14'd2000);
        issue_item(OP_SET_YEAR, '0, '0, '0, 14'd2100);
        issue_item(OP_LOAD, '0, 5'd31, JANUARY, 14'd2000);
        issue_item(OP_SET_MONTH, '0, '0, 4'd2, '0);
        issue_item(OP_LOAD, '0, '0, '0, '0);
        issue_item(OP_SUB_MON, 12'd1, '0, '0, '0);
        issue_item(OP_SUB_YEARS, 12'd1, '0, '0, '0);
        issue_item(OP_LOAD, '0, 5'd31, 4'd15, 14'd16383);
        issue_item(OP_ADD_MON, 12'd4095, '0, '0, '0);
        issue_item(OP_LOAD, '0, 5'd31, 4'd2, 14'd1900);
        issue_item(OP_ADD_DAYS, 12'd4095, '0, '0, '0);
        issue_item(OP_SUB_MON, 12'd4095, '0, '0, '0);
        issue_item(OP_ADD_YEARS, 12'd4095, '0, '0, '0);
        issue_item(OP_ADD_YEARS, 12'd4095, '0, '0, '0);
        issue_item(OP_SUB_YEARS, 12'd4095, '0, '0, '0);
        issue_item(OP_COMPARE, '0, '0, '0, '0);
        issue_item(OP_COMPARE, 12'd4095, 5'd31, 4'd15, 14'd16383);
        issue_item(OP_SET_MONTH, '0, '0, '0, '0);
        issue_item(OP_SET_MONTH, '0, '0, 4'd13, '0);
        issue_item(OP_SET_YEAR, '0, '0, '0, 14'd16383);
        issue_item(OP_FIRST_UNUSED, 12'd4095, 5'd31, 4'd15, 14'd16383);
        issue_item(OP_LAST_UNUSED, '0, '0, '0, '0);
        drain_results();

        // random sequences
        next_drain = items_sent + DRAIN_EVERY;
        while (items_sent < TOTAL_ITEMS)
        begin
            if ($urandom_range(0, 19) == 0)
                no_idle = !no_idle;
            if (items_sent >= next_drain)
            begin
                drain_results();
                next_drain += DRAIN_EVERY;
            end
            scenario = $urandom_range(0, 99);
            if (scenario < 30)
                random_op();
            else if (scenario < 60)
            begin
                issue_item(OP_LOAD, rand_amount(), rand_day(), rand_month(), rand_year());
                repeat ($urandom_range(2, 5))
                    arith_op();
            end
            else if (scenario < 80)
                load_and_compare();
            else
                edge_walk();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.flag_mismatch($sformatf("%0d results never arrived", sb.pending()));
        sb.summary();
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
